### sv/mwgg_pkg.sv
// ---------------------------------------------------------------------------
// mwgg_pkg: month week grid generator shared types and constants
// Field widths, reciprocal constants, state encoding and calendar tables.
// ---------------------------------------------------------------------------
package mwgg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 15;
    localparam int PROD_W = 2 * MUL_W;

    // floor(x/100) = (x * 5243) >> 19 exact for x < 43690
    localparam logic [MUL_W-1:0] RECIP_100 = 15'd5243;
    localparam int               SHIFT_100 = 19;
    localparam int               Q100_W    = 7;
    // floor(x/7) = (x * 18725) >> 17 exact for x < 43690
    localparam logic [MUL_W-1:0] RECIP_7   = 15'd18725;
    localparam int               SHIFT_7   = 17;
    localparam int               Q7_W      = 11;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [COL_W-1:0]   COL_SUN   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV100,
        ST_SUM,
        ST_DIV7,
        ST_START,
        ST_EMIT
    } t_state;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    // month offsets for the Sunday-based day-of-week sum
    function automatic logic [2:0] month_key(input logic [MONTH_W-1:0] m);
        logic [2:0] k;
        unique case (m)
            4'd1:    k = 3'd0;
            4'd2:    k = 3'd3;
            4'd3:    k = 3'd2;
            4'd4:    k = 3'd5;
            4'd5:    k = 3'd0;
            4'd6:    k = 3'd3;
            4'd7:    k = 3'd5;
            4'd8:    k = 3'd1;
            4'd9:    k = 3'd4;
            4'd10:   k = 3'd6;
            4'd11:   k = 3'd2;
            4'd12:   k = 3'd4;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

### sv/mwgg_req_if.sv
// ---------------------------------------------------------------------------
// mwgg_req_if: request channel
// Valid/ready channel carrying the requested year and month.
// ---------------------------------------------------------------------------
interface mwgg_req_if;
    import mwgg_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;

    modport source (output valid, output year, output month, input ready);
    modport sink   (input valid, input year, input month, output ready);
endinterface

### sv/mwgg_date_if.sv
// ---------------------------------------------------------------------------
// mwgg_date_if: grid date channel
// Valid/ready channel carrying one grid date word per handshake.
// ---------------------------------------------------------------------------
interface mwgg_date_if;
    import mwgg_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  date_year;
    logic [MONTH_W-1:0] date_month;
    logic [DAY_W-1:0]   date_day;
    logic [ROW_W-1:0]   week_row;
    logic [COL_W-1:0]   weekday;
    logic               in_month;
    logic               last;

    modport source (output valid, output date_year, output date_month, output date_day,
                    output week_row, output weekday, output in_month, output last,
                    input ready);
    modport sink   (input valid, input date_year, input date_month, input date_day,
                    input week_row, input weekday, input in_month, input last,
                    output ready);
endinterface

### sv/month_week_grid_generator_unit.sv
// ---------------------------------------------------------------------------
// month_week_grid_generator_unit: ISO week calendar grid of one month
// Takes a year and month, emits 28 to 42 dates Monday to Sunday, row by row.
// ---------------------------------------------------------------------------
//  channel   dir  fields                                            words/item
//  i_req     in   year, month                                       1
//  o_date    out  date_year, date_month, date_day, week_row,        28..42
//                 weekday, in_month, last
//
//  A valid request passes through setup states ST_DIV100, ST_SUM, ST_DIV7
//  and ST_START (two passes through one shared 15x15 multiplier: divide by
//  100, then mod 7), then one date word per cycle while o_date.ready is
//  high. An out-of-range request is taken and produces nothing. i_req.ready
//  is high only when idle. Stalls on o_date hold the word. Synchronous
//  active-low reset returns to idle.
// ---------------------------------------------------------------------------
module month_week_grid_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwgg_req_if.sink    i_req,
    mwgg_date_if.source o_date
);
    import mwgg_pkg::*;

    t_state r_state, n_state;

    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [MUL_W-1:0]   r_sum, n_sum;
    logic [DAY_W-1:0]   r_mld, n_mld;
    logic [DAY_W-1:0]   r_plen, n_plen;
    logic [YEAR_W-1:0]  r_cur_year, n_cur_year;
    logic [MONTH_W-1:0] r_cur_month, n_cur_month;
    logic [DAY_W-1:0]   r_cur_day, n_cur_day;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;

    logic req_fire, req_ok, date_fire;
    logic in_month, last_word;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;

    // setup arithmetic
    logic [Q100_W-1:0] q100y, q100yy;
    logic [YEAR_W-1:0] r100, yy;
    logic              early, leap;
    logic [Q7_W-1:0]   q7;
    logic [MUL_W-1:0]  rem_full;
    logic [2:0]        offset;
    logic [DAY_W-1:0]  cur_len;

    assign req_fire  = i_req.valid && i_req.ready;
    assign req_ok    = (i_req.year >= YEAR_MIN) && (i_req.year <= YEAR_MAX)
                    && (i_req.month >= MONTH_JAN) && (i_req.month <= MONTH_DEC);
    assign date_fire = o_date.valid && o_date.ready;

    assign in_month  = (r_cur_year == r_year) && (r_cur_month == r_month);
    // row 0 ends inside the month, so a Sunday outside it is past the end
    assign last_word = (r_col == COL_SUN) && (!in_month || (r_cur_day == r_mld));

    assign mul_a = (r_state == ST_DIV100) ? {1'b0, r_year} : r_sum;
    assign mul_b = (r_state == ST_DIV100) ? RECIP_100 : RECIP_7;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        q100y  = r_prod[SHIFT_100 +: Q100_W];
        r100   = r_year - YEAR_W'({7'd0, q100y} * 14'd100);
        leap   = (r_year[1:0] == 2'b00) && ((r100 != '0) || (q100y[1:0] == 2'b00));
        early  = (r_month < MONTH_MAR);
        yy     = early ? (r_year - 14'd1) : r_year;
        q100yy = (early && (r100 == '0)) ? (q100y - 7'd1) : q100y;
        q7       = r_prod[SHIFT_7 +: Q7_W];
        rem_full = r_sum - MUL_W'({4'd0, q7} * 15'd7);
        offset   = (rem_full[2:0] == 3'd0) ? 3'd6 : (rem_full[2:0] - 3'd1);
        cur_len  = in_month ? r_mld : r_plen;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (req_fire && req_ok) n_state = ST_DIV100;
            ST_DIV100: n_state = ST_SUM;
            ST_SUM:    n_state = ST_DIV7;
            ST_DIV7:   n_state = ST_START;
            ST_START:  n_state = ST_EMIT;
            ST_EMIT:   if (date_fire && last_word) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_req.ready  = (r_state == ST_IDLE);
        o_date.valid = (r_state == ST_EMIT);
    end

    assign o_date.date_year  = r_cur_year;
    assign o_date.date_month = r_cur_month;
    assign o_date.date_day   = r_cur_day;
    assign o_date.week_row   = r_row;
    assign o_date.weekday    = r_col;
    assign o_date.in_month   = in_month;
    assign o_date.last       = last_word;

    // datapath
    always_comb begin
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_mld       = r_mld;
        n_plen      = r_plen;
        n_cur_year  = r_cur_year;
        n_cur_month = r_cur_month;
        n_cur_day   = r_cur_day;
        n_row       = r_row;
        n_col       = r_col;
        unique case (r_state)
            ST_DIV100,
            ST_DIV7: begin
                n_prod = mul_p;
            end
            ST_SUM: begin
                n_sum  = {1'b0, yy} + {3'b0, yy[YEAR_W-1:2]} - {8'b0, q100yy}
                       + {10'b0, q100yy[Q100_W-1:2]} + {12'b0, month_key(r_month)}
                       + 15'd1;
                n_mld  = month_len(r_month, leap);
                n_plen = (r_month == MONTH_JAN) ? 5'd31
                                                : month_len(r_month - 4'd1, leap);
            end
            ST_START: begin
                n_row = '0;
                n_col = '0;
                if (offset == 3'd0) begin
                    n_cur_year  = r_year;
                    n_cur_month = r_month;
                    n_cur_day   = 5'd1;
                end else if (r_month == MONTH_JAN) begin
                    n_cur_year  = r_year - 14'd1;
                    n_cur_month = MONTH_DEC;
                    n_cur_day   = 5'd31 - {2'b0, offset} + 5'd1;
                end else begin
                    n_cur_year  = r_year;
                    n_cur_month = r_month - 4'd1;
                    n_cur_day   = r_plen - {2'b0, offset} + 5'd1;
                end
            end
            ST_EMIT: begin
                if (date_fire && !last_word) begin
                    if (r_cur_day >= cur_len) begin
                        n_cur_day = 5'd1;
                        if (r_cur_month >= MONTH_DEC) begin
                            n_cur_month = MONTH_JAN;
                            n_cur_year  = r_cur_year + 14'd1;
                        end else begin
                            n_cur_month = r_cur_month + 4'd1;
                        end
                    end else begin
                        n_cur_day = r_cur_day + 5'd1;
                    end
                    if (r_col == COL_SUN) begin
                        n_col = '0;
                        n_row = r_row + 3'd1;
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mld       <= '0;
            r_cur_year  <= '0;
            r_cur_month <= MONTH_JAN;
            r_cur_day   <= 5'd1;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_mld       <= n_mld;
            r_cur_year  <= n_cur_year;
            r_cur_month <= n_cur_month;
            r_cur_day   <= n_cur_day;
            r_row       <= n_row;
            r_col       <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_year  <= i_req.year;
            r_month <= i_req.month;
        end
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_plen <= n_plen;
    end

endmodule

### sv/mwgg_checker.sv
// ---------------------------------------------------------------------------
// mwgg_checker: port-level checks for the month week grid generator
// Watches the request and date channels; bound to the top level.
// ---------------------------------------------------------------------------
module mwgg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_date_valid,
    input logic       i_date_ready,
    input logic [2:0] i_weekday,
    input logic [2:0] i_week_row,
    input logic       i_last
);
    import mwgg_pkg::*;

    // no new request while a grid is going out
    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_date_valid |-> !i_req_ready)
        else $error("request ready while dates pending");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_date_valid)
        else $error("date word valid after reset");

    // the grid ends only on a Sunday
    a_last_sunday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_date_valid && i_last) |-> (i_weekday == COL_SUN))
        else $error("last word not on Sunday");

    // columns step Monday to Sunday and wrap into the next row
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_date_valid && i_date_ready && !i_last) |=>
            (i_date_valid
             && (($past(i_weekday) == COL_SUN) ? (i_weekday == 3'd0
                                                && i_week_row == $past(i_week_row) + 3'd1)
                                             : (i_weekday == $past(i_weekday) + 3'd1
                                                && i_week_row == $past(i_week_row)))))
        else $error("grid position did not advance by one");
endmodule

bind month_week_grid_generator_unit mwgg_checker u_mwgg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_date_valid (o_date.valid),
    .i_date_ready (o_date.ready),
    .i_weekday    (o_date.weekday),
    .i_week_row   (o_date.week_row),
    .i_last       (o_date.last)
);

### dv/tb_month_week_grid_generator_unit.sv
// ---------------------------------------------------------------------------
// tb_month_week_grid_generator_unit: month week grid generator testbench
// Sends year/month requests (directed corners, then random), predicts each
// month's Monday-first grid and checks every date word in order, under
// random idling on both channels, with none for the last third of requests.
// ---------------------------------------------------------------------------
module tb_month_week_grid_generator_unit;
    import mwgg_pkg::*;

    localparam int N_RANDOM    = 340;
    localparam int SETTLE_CYC  = 60;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        bit                 drain;   // hold until all outstanding dates are back
    } t_month_req;

    typedef struct {
        logic [YEAR_W-1:0]  date_year;
        logic [MONTH_W-1:0] date_month;
        logic [DAY_W-1:0]   date_day;
        logic [ROW_W-1:0]   week_row;
        logic [COL_W-1:0]   weekday;
        logic               in_month;
        logic               last;
    } t_grid_date;

    // Sunday-based month keys for the weekday sum
    localparam int SUN_KEY [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int DAYS_IN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic i_clk;
    logic i_rst_n;

    mwgg_req_if  req_ch ();
    mwgg_date_if date_ch ();

    month_week_grid_generator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_date  (date_ch)
    );

    t_month_req request_q [$];
    t_grid_date grid_q [$];
    t_month_req next_req;
    t_grid_date got_date;
    t_grid_date exp_date;
    int         n_errors;
    int         n_requests;
    int         n_taken;

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_of(int y, int m);
        if (m == 2 && leap_year(y))
            return 29;
        return DAYS_IN[m-1];
    endfunction

    // 0 Monday .. 6 Sunday for the 1st of the month
    function automatic int first_weekday(int y, int m);
        int yy;
        int sun0;
        yy   = (m < 3) ? y - 1 : y;
        sun0 = (yy + yy / 4 - yy / 100 + yy / 400 + SUN_KEY[m-1] + 1) % 7;
        return (sun0 + 6) % 7;
    endfunction

    function automatic void predict_grid(int y, int m);
        int         len;
        int         off;
        int         total;
        int         yr;
        int         mo;
        int         d;
        t_grid_date g;
        if (y < 1 || y > 9999 || m < 1 || m > 12)
            return;
        len   = days_of(y, m);
        off   = first_weekday(y, m);
        total = ((off + len + 6) / 7) * 7;
        if (off == 0) begin
            yr = y; mo = m; d = 1;
        end else if (m == 1) begin
            yr = y - 1; mo = 12; d = 32 - off;
        end else begin
            yr = y; mo = m - 1; d = days_of(y, m - 1) - off + 1;
        end
        for (int k = 0; k < total; k++) begin
            g.date_year  = yr[YEAR_W-1:0];
            g.date_month = mo[MONTH_W-1:0];
            g.date_day   = d[DAY_W-1:0];
            g.week_row   = ROW_W'(k / 7);
            g.weekday    = COL_W'(k % 7);
            g.in_month   = (yr == y) && (mo == m);
            g.last       = (k == total - 1);
            grid_q.insert(grid_q.size(), g);
            if (d >= days_of(yr, mo)) begin
                d = 1;
                if (mo == 12) begin
                    mo = 1;
                    yr = yr + 1;
                end else begin
                    mo = mo + 1;
                end
            end else begin
                d = d + 1;
            end
        end
    endfunction

    function automatic void add_request(int y, int m, bit drain = 1'b0);
        t_month_req r;
        r.year  = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.drain = drain;
        request_q.insert(request_q.size(), r);
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            n_errors++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // idle percentages: phase 0 sender 27 / receiver 65, phase 1 swapped, then none
    function automatic int phase_of();
        if (n_taken * 3 < n_requests)
            return 0;
        if (n_taken * 3 < n_requests * 2)
            return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (phase_of())
            0:       return 27;
            1:       return 65;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (phase_of())
            0:       return 65;
            1:       return 27;
            default: return 0;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.year  <= '0;
            req_ch.month <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_grid(req_ch.year, req_ch.month);
                n_taken++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (request_q.size() != 0 && !(request_q[0].drain && grid_q.size() != 0)
                        && $urandom_range(99) >= sender_idle_pct()) begin
                    next_req = request_q.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.year  <= next_req.year;
                    req_ch.month <= next_req.month;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // date word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            date_ch.ready <= 1'b0;
        end else begin
            if (date_ch.valid && date_ch.ready) begin
                got_date.date_year  = date_ch.date_year;
                got_date.date_month = date_ch.date_month;
                got_date.date_day   = date_ch.date_day;
                got_date.week_row   = date_ch.week_row;
                got_date.weekday    = date_ch.weekday;
                got_date.in_month   = date_ch.in_month;
                got_date.last       = date_ch.last;
                if (grid_q.size() == 0) begin
                    n_errors++;
                    $display("%0t unexpected date word: expected none, actual %0d-%0d-%0d",
                             $time, got_date.date_year, got_date.date_month,
                             got_date.date_day);
                end else begin
                    exp_date = grid_q.pop_front();
                    check_field("date_year",  exp_date.date_year,  got_date.date_year);
                    check_field("date_month", exp_date.date_month, got_date.date_month);
                    check_field("date_day",   exp_date.date_day,   got_date.date_day);
                    check_field("week_row",   exp_date.week_row,   got_date.week_row);
                    check_field("weekday",    exp_date.weekday,    got_date.weekday);
                    check_field("in_month",   exp_date.in_month,   got_date.in_month);
                    check_field("last",       exp_date.last,       got_date.last);
                end
            end
            date_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    initial begin
        int y;
        int m;
        int pick;
        int n_valid;

        n_errors      = 0;
        n_taken       = 0;
        i_rst_n       = 1'b0;

        // directed corners
        add_request(1, 1);          // 1st on Monday: no leading dates from year 0
        add_request(9999, 12);      // trailing dates fall in year 10000
        add_request(2021, 2);       // 28 days starting Monday: four rows
        add_request(2015, 2);       // 1st on Sunday
        add_request(2000, 2, 1'b1); // leap century
        add_request(1900, 2);       // non-leap century
        add_request(2024, 2);       // plain leap year
        add_request(2021, 8);       // 31 days starting Sunday: six rows
        add_request(2023, 1);       // leading dates from previous December
        add_request(2023, 12);      // 31st on Sunday: no trailing dates into next January
        add_request(1, 12);
        add_request(9999, 1);
        add_request(400, 3);        // February of a leap century ahead
        add_request(2100, 3);       // 1st on Monday: no dates of the non-leap century February ahead
        add_request(0, 5);          // rejected: year too small
        add_request(10000, 6);      // rejected: year too large
        add_request(16383, 15);     // rejected: all field bits set
        add_request(2020, 0);       // rejected: month zero
        add_request(2020, 13);      // rejected: month too large
        add_request(0, 0);
        add_request(5461, 7);
        add_request(10922, 10);     // rejected, alternating year bits

        // random: mostly well-formed months, a share of rejected requests
        n_valid = 0;
        while (n_valid < N_RANDOM) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                case ($urandom_range(3))
                    0:       add_request(0, $urandom_range(15));
                    1:       add_request($urandom_range(16383, 10000), $urandom_range(15));
                    2:       add_request($urandom_range(16383), 0);
                    default: add_request($urandom_range(16383), $urandom_range(15, 13));
                endcase
            end else begin
                if (pick < 20)
                    y = ($urandom_range(1) != 0) ? $urandom_range(3, 1)
                                                 : $urandom_range(9999, 9997);
                else if (pick < 30)
                    y = $urandom_range(99, 1) * 100;
                else
                    y = $urandom_range(9999, 1);
                m = ($urandom_range(4) == 0) ? 2 : $urandom_range(12, 1);
                add_request(y, m, (n_valid % 100) == 50);
                n_valid++;
            end
        end
        n_requests = request_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || req_ch.valid || grid_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (n_errors == 0 && grid_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### month_week_grid_generator_unit.f
sv/mwgg_pkg.sv
sv/mwgg_req_if.sv
sv/mwgg_date_if.sv
sv/month_week_grid_generator_unit.sv
sv/mwgg_checker.sv
dv/tb_month_week_grid_generator_unit.sv
